// File: hdl/obb_pkg.sv
// Shared types, widths and helper functions for the orthonormal basis builder.
// No dependencies; every other file imports this package.
package obb_pkg;

  localparam int FRACTION_BITS = 14;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int MAG_W  = PROD_W - 1;
  localparam int NUM_W  = PROD_W;
  // d = one + |z| needs room for both 2^FRACTION_BITS and 2^(VAL_W-1)
  localparam int D_W    = ((FRACTION_BITS > VAL_W - 1) ? FRACTION_BITS : VAL_W - 1) + 2;
  localparam int DEN_W  = D_W + 1;
  // quotient never exceeds 2^(2*(VAL_W-1) - FRACTION_BITS)
  localparam int QUO_W  = 2 * (VAL_W - 1) + 1 - FRACTION_BITS;
  localparam int REM_W  = DEN_W + QUO_W;
  localparam int RES_W  = 33;

  localparam logic [D_W-1:0] ONE_D = {{(D_W - 1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic signed [RES_W-1:0] ONE_RES =
    {{(RES_W - 1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-32768);

  typedef struct packed {
    logic signed [VAL_W-1:0] normal_x;
    logic signed [VAL_W-1:0] normal_y;
    logic signed [VAL_W-1:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] tangent_x;
    logic signed [VAL_W-1:0] tangent_y;
    logic signed [VAL_W-1:0] tangent_z;
    logic signed [VAL_W-1:0] bitangent_x;
    logic signed [VAL_W-1:0] bitangent_y;
    logic signed [VAL_W-1:0] bitangent_z;
  } out_item_t;

  typedef struct packed {
    logic                    z_neg;
    logic                    xy_neg;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        xx;
    div_lane_t        yy;
    div_lane_t        xy;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_word_t;

  // one restoring-division step: shift in the next quotient bit
  function automatic div_lane_t div_step(div_lane_t a, logic [REM_W-1:0] den_sh);
    div_lane_t r;
    r     = a;
    r.quo = a.quo << 1;
    if (a.rem >= den_sh) begin
      r.rem    = a.rem - den_sh;
      r.quo[0] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[VAL_W-1:0];
  endfunction

endpackage

// File: hdl/orthonormal_basis_builder.sv
// Orthonormal basis builder. For a unit normal in signed Q2.14 it returns a
// tangent and a bitangent (branch-on-sign construction, divisor 1 + |z| in
// [1, 2]) with quotients rounded to nearest, ties away from zero, and every
// component saturated to 16 bits. One request is taken per clock unless a
// stalled output has filled every stage; each request passes through the
// front-end registers, the restoring divider that resolves one quotient
// bit per stage, and the output register. Every stage holds its own valid
// bit, so empty stages fill while the output waits to be taken.
// Depends on obb_pkg, obb_front, obb_div_pipe and obb_back.
module orthonormal_basis_builder
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      f_valid;
  logic      f_ready;
  div_word_t f_data;
  logic      d_valid;
  logic      d_ready;
  div_word_t d_data;

  obb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  obb_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  obb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/obb_front.sv
// Front end: products, |z| and the rounding numerators, two register stages.
// Depends on obb_pkg.
module obb_front
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_word_t out_data
);

  logic                     a_valid;
  logic [MAG_W-1:0]         a_xx;
  logic [MAG_W-1:0]         a_yy;
  logic signed [PROD_W-1:0] a_xy;
  logic [D_W-1:0]           a_d;
  logic                     a_z_neg;
  logic signed [VAL_W-1:0]  a_x;
  logic signed [VAL_W-1:0]  a_y;

  logic                     a_ready;
  logic                     b_ready;

  logic signed [PROD_W-1:0] prod_xx;
  logic signed [PROD_W-1:0] prod_yy;
  logic signed [PROD_W-1:0] prod_xy;
  logic signed [VAL_W:0]    z_ext;
  logic [VAL_W:0]           abs_z;
  logic [D_W-1:0]           d_val;

  logic [PROD_W-1:0]        xy_abs;
  logic [NUM_W-1:0]         num_xx;
  logic [NUM_W-1:0]         num_yy;
  logic [NUM_W-1:0]         num_xy;
  div_word_t                b_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    prod_xx = PROD_W'(in_data.normal_x) * PROD_W'(in_data.normal_x);
    prod_yy = PROD_W'(in_data.normal_y) * PROD_W'(in_data.normal_y);
    prod_xy = PROD_W'(in_data.normal_x) * PROD_W'(in_data.normal_y);
    z_ext   = {in_data.normal_z[VAL_W-1], in_data.normal_z};
    abs_z   = (z_ext < 0) ? $unsigned(-z_ext) : $unsigned(z_ext);
    d_val   = ONE_D + D_W'(abs_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_xx    <= prod_xx[MAG_W-1:0];
      a_yy    <= prod_yy[MAG_W-1:0];
      a_xy    <= prod_xy;
      a_d     <= d_val;
      a_z_neg <= in_data.normal_z[VAL_W-1];
      a_x     <= in_data.normal_x;
      a_y     <= in_data.normal_y;
    end
  end

  // round to nearest, ties away: (2*|p| + d) / (2*d)
  always_comb begin
    xy_abs = (a_xy < 0) ? $unsigned(-a_xy) : $unsigned(a_xy);
    num_xx = {a_xx, 1'b0} + NUM_W'(a_d);
    num_yy = {a_yy, 1'b0} + NUM_W'(a_d);
    num_xy = {xy_abs[MAG_W-1:0], 1'b0} + NUM_W'(a_d);

    b_next             = '0;
    b_next.xx.rem      = REM_W'(num_xx);
    b_next.yy.rem      = REM_W'(num_yy);
    b_next.xy.rem      = REM_W'(num_xy);
    b_next.den         = {a_d, 1'b0};
    b_next.side.z_neg  = a_z_neg;
    b_next.side.xy_neg = a_xy < 0;
    b_next.side.x      = a_x;
    b_next.side.y      = a_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

// File: hdl/obb_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, three lanes sharing
// one divisor. Depends on obb_pkg.
module obb_div_pipe
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_word_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_word_t out_data
);

  div_word_t st        [QUO_W];
  logic      st_valid  [QUO_W];
  div_word_t din       [QUO_W];
  logic      din_valid [QUO_W];
  logic      acc_ready [QUO_W];
  logic      down_ready[QUO_W];

  assign din[0]       = in_data;
  assign din_valid[0] = in_valid;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;

    logic [REM_W-1:0] den_sh;
    div_word_t        nxt;

    assign den_sh = REM_W'(din[k].den) << SH;

    always_comb begin
      nxt    = din[k];
      nxt.xx = div_step(din[k].xx, den_sh);
      nxt.yy = div_step(din[k].yy, den_sh);
      nxt.xy = div_step(din[k].xy, den_sh);
    end

    assign acc_ready[k] = !st_valid[k] || down_ready[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (acc_ready[k]) begin
        st_valid[k] <= din_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (acc_ready[k] && din_valid[k]) begin
        st[k] <= nxt;
      end
    end

    if (k + 1 < QUO_W) begin : g_link
      assign din[k+1]       = st[k];
      assign din_valid[k+1] = st_valid[k];
      assign down_ready[k]  = acc_ready[k+1];
    end else begin : g_last
      assign down_ready[k]  = out_ready;
    end
  end

  assign in_ready  = acc_ready[0];
  assign out_valid = st_valid[QUO_W-1];
  assign out_data  = st[QUO_W-1];

endmodule

// File: hdl/obb_back.sv
// Output stage: apply signs, pick the z-sign branch, saturate, register result.
// Depends on obb_pkg.
module obb_back
  import obb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_word_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic signed [RES_W-1:0] xxa;
  logic signed [RES_W-1:0] yya;
  logic signed [RES_W-1:0] xya;
  logic signed [RES_W-1:0] xya_s;
  logic signed [RES_W-1:0] x_ext;
  logic signed [RES_W-1:0] y_ext;
  out_item_t               res;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xxa   = $signed({{(RES_W - QUO_W){1'b0}}, in_data.xx.quo});
    yya   = $signed({{(RES_W - QUO_W){1'b0}}, in_data.yy.quo});
    xya   = $signed({{(RES_W - QUO_W){1'b0}}, in_data.xy.quo});
    xya_s = in_data.side.xy_neg ? -xya : xya;
    x_ext = RES_W'(in_data.side.x);
    y_ext = RES_W'(in_data.side.y);

    res.tangent_x   = sat16(ONE_RES - xxa);
    res.tangent_y   = sat16(-xya_s);
    res.bitangent_z = sat16(-y_ext);
    if (in_data.side.z_neg) begin
      res.tangent_z   = sat16(x_ext);
      res.bitangent_x = sat16(xya_s);
      res.bitangent_y = sat16(yya - ONE_RES);
    end else begin
      res.tangent_z   = sat16(-x_ext);
      res.bitangent_x = sat16(-xya_s);
      res.bitangent_y = sat16(ONE_RES - yya);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

// File: hdl/obb_checker.sv
// Port-level checks for the orthonormal basis builder, bound to the top level.
// Depends on obb_pkg and orthonormal_basis_builder.
module obb_checker
  import obb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // reset empties the pipe and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipe not empty after reset");

  // input can only back up when every stage, the output included, is full
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an open output keeps the whole pipe, and so the input, moving
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with output free");

  // a waiting request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting request changed");

endmodule

bind orthonormal_basis_builder obb_checker u_obb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: bench/tb.sv
// Self-checking bench for orthonormal_basis_builder: random unit and raw normals,
// bursty requests, a stalling output side, and a long output hold-off.
// Depends on obb_pkg and the RTL of the block.
module tb;
  import obb_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int LATENCY     = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int ONE_Q       = 1 << FRACTION_BITS;
  localparam longint TIMEOUT = 64'd400000 * CLK_PERIOD;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  out_item_t basis_q[$];
  int        mismatch_count;
  bit        hold_off_req;
  int        burst_left;
  out_item_t want;
  string     field_name[6] = '{"tangent_x", "tangent_y", "tangent_z",
                               "bitangent_x", "bitangent_y", "bitangent_z"};

  orthonormal_basis_builder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("DONE: errors detected");
    $finish;
  end

  // round(num / den), ties away from zero; den is always positive
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic out_item_t predict_basis(in_item_t n);
    longint one;
    longint x;
    longint y;
    longint z;
    longint d;
    longint xx;
    longint yy;
    longint xy;
    out_item_t r;
    one = longint'(1) << FRACTION_BITS;
    x   = longint'(n.normal_x);
    y   = longint'(n.normal_y);
    z   = longint'(n.normal_z);
    d   = one + ((z < 0) ? -z : z);
    xx  = round_div(x * x, d);
    yy  = round_div(y * y, d);
    xy  = round_div(x * y, d);
    r.tangent_x   = clamp16(one - xx);
    r.tangent_y   = clamp16(-xy);
    r.bitangent_z = clamp16(-y);
    // negative z flips the cross term of b, the sign of b.y and of t.z
    if (z < 0) begin
      r.tangent_z   = clamp16(x);
      r.bitangent_x = clamp16(xy);
      r.bitangent_y = clamp16(yy - one);
    end else begin
      r.tangent_z   = clamp16(-x);
      r.bitangent_x = clamp16(-xy);
      r.bitangent_y = clamp16(one - yy);
    end
    return r;
  endfunction

  task automatic send_normal(in_item_t n);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= n;
    do @(posedge clk); while (!in_ready);
    basis_q.insert(basis_q.size(), predict_basis(n));
  endtask

  // end a burst with a random gap; some bursts run with no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 25);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic test_directed();
    in_item_t n;
    int k;
    logic signed [VAL_W-1:0] pts[17][3] = '{
      '{16'sd0, 16'sd0, 16'sd16384},
      '{16'sd0, 16'sd0, -16'sd16384},
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd16384, 16'sd0, 16'sd0},
      '{-16'sd16384, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd16384, 16'sd0},
      '{16'sd0, -16'sd16384, 16'sd0},
      '{16'sd9459, 16'sd9459, 16'sd9459},
      '{16'sd9459, -16'sd9459, -16'sd9459},
      '{-16'sd9459, 16'sd9459, -16'sd9459},
      '{16'sd0, 16'sd16384, -16'sd1},
      '{16'sd16384, 16'sd0, 16'sd1},
      '{16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{16'sh8000, 16'sh7fff, 16'sd0},
      '{16'sh7fff, 16'sh8000, -16'sd1},
      '{16'sd16384, 16'sd16384, 16'sd16384}
    };
    for (k = 0; k < 17; k++) begin
      n.normal_x = pts[k][0];
      n.normal_y = pts[k][1];
      n.normal_z = pts[k][2];
      send_normal(n);
    end
  endtask

  task automatic test_unit_normals(int count);
    in_item_t n;
    int a;
    int b;
    int c;
    int sent;
    sent = 0;
    while (sent < count) begin
      a = $urandom_range(2 * ONE_Q) - ONE_Q;
      b = $urandom_range(2 * ONE_Q) - ONE_Q;
      if (a * a + b * b <= ONE_Q * ONE_Q) begin
        c = $rtoi($sqrt(real'(ONE_Q * ONE_Q - a * a - b * b)));
        if ($urandom_range(1)) c = -c;
        // rotate the derived component so any axis can be near one
        case ($urandom_range(2))
          0: n = '{VAL_W'(c), VAL_W'(a), VAL_W'(b)};
          1: n = '{VAL_W'(a), VAL_W'(c), VAL_W'(b)};
          default: n = '{VAL_W'(a), VAL_W'(b), VAL_W'(c)};
        endcase
        send_normal(n);
        pace_sender();
        sent++;
      end
    end
  endtask

  task automatic test_raw_patterns(int count);
    in_item_t n;
    logic signed [VAL_W-1:0] f[3];
    int k;
    int j;
    for (k = 0; k < count; k++) begin
      for (j = 0; j < 3; j++) begin
        case ($urandom_range(7))
          0: f[j] = 16'sd0;
          1: f[j] = 16'sh8000;
          2: f[j] = 16'sh7fff;
          3: f[j] = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
          4: f[j] = VAL_W'($urandom_range(2 * ONE_Q) - ONE_Q);
          default: f[j] = VAL_W'($urandom);
        endcase
      end
      n = '{f[0], f[1], f[2]};
      send_normal(n);
      pace_sender();
    end
  endtask

  // hold the output while requests keep coming, so the pipe fills and stalls
  task automatic test_output_backpressure(int count);
    in_item_t n;
    int k;
    hold_off_req = 1'b1;
    for (k = 0; k < count; k++) begin
      n = '{VAL_W'($urandom), VAL_W'($urandom_range(2 * ONE_Q) - ONE_Q),
            VAL_W'($urandom_range(2 * ONE_Q) - ONE_Q)};
      send_normal(n);
    end
  endtask

  initial begin
    int phase_left;
    int mode;
    out_ready  = 1'b0;
    phase_left = 0;
    mode       = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(3);
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(1);
          2: out_ready <= ($urandom_range(3) == 0);
          default: out_ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = basis_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (out_data[(5 - k) * VAL_W +: VAL_W] !== want[(5 - k) * VAL_W +: VAL_W]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                     $signed(want[(5 - k) * VAL_W +: VAL_W]),
                     $signed(out_data[(5 - k) * VAL_W +: VAL_W]));
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    hold_off_req   = 1'b0;
    burst_left     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_unit_normals(800);
    test_output_backpressure(120);
    test_raw_patterns(330);

    @(negedge clk);
    in_valid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (basis_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, basis_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/obb_pkg.sv
hdl/obb_front.sv
hdl/obb_div_pipe.sv
hdl/obb_back.sv
hdl/orthonormal_basis_builder.sv
hdl/obb_checker.sv
bench/tb.sv
